### src/gbm_pkg.sv
// Shared types, constants and a lookup function for the GBM path generator.
package gbm_pkg;

   localparam int FRAC_BITS = 24;
   localparam int MAX_STEPS = 4096;
   localparam int STEP_W    = 12;
   localparam int EXP_TERMS = 13;

   localparam logic [28:0] LOG2E_Q28 = 29'd387270501;
   localparam logic [29:0] LN2_Q30   = 30'd744261118;
   localparam logic [28:0] X_LIMIT   = 29'd385875968;
   localparam logic [30:0] DRIFT_CAP = 31'h4000_0000;
   localparam logic [30:0] ONE_Q30   = 31'h4000_0000;

   localparam logic [2:0] CSR_START_PRICE    = 3'd0;
   localparam logic [2:0] CSR_DRIFT_RATE     = 3'd1;
   localparam logic [2:0] CSR_VOLATILITY     = 3'd2;
   localparam logic [2:0] CSR_START_LEVEL    = 3'd3;
   localparam logic [2:0] CSR_TIME_STEP      = 3'd4;
   localparam logic [2:0] CSR_STEPS_PER_PATH = 3'd5;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_OVERFLOW  = 2'd1;
   localparam logic [1:0] STATUS_UNDERFLOW = 2'd2;

   typedef struct packed {
      logic signed [31:0] level;
      logic [STEP_W-1:0]  step;
      logic               last;
   } job_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_HALF, ST_TIME, ST_DRIFT_LO, ST_DRIFT_HI, ST_DIFF, ST_SUM,
      ST_LOG, ST_FRAC, ST_Z, ST_TERM_MUL, ST_TERM_DIV, ST_TERM_FIX, ST_SCALE, ST_OUT
   } back_state_type;

   // floor(2^32 / i) for the series divisors.
   function automatic logic [32:0] recip(input logic [3:0] i);
      logic [32:0] r;
      unique case (i)
         4'd1:    r = 33'd4294967296;
         4'd2:    r = 33'd2147483648;
         4'd3:    r = 33'd1431655765;
         4'd4:    r = 33'd1073741824;
         4'd5:    r = 33'd858993459;
         4'd6:    r = 33'd715827882;
         4'd7:    r = 33'd613566756;
         4'd8:    r = 33'd536870912;
         4'd9:    r = 33'd477218588;
         4'd10:   r = 33'd429496729;
         4'd11:   r = 33'd390451572;
         4'd12:   r = 33'd357913941;
         4'd13:   r = 33'd330382099;
         default: r = 33'd0;
      endcase
      return r;
   endfunction

endpackage

### src/gbm_front.sv
// Request intake: tracks path level and step count, queues jobs for the back end.
module gbm_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_push,
   output logic                            req_full,
   input  logic signed [31:0]              req_increment,
   input  logic                            req_path_start,
   input  logic [31:0]                     start_level,
   input  logic [12:0]                     steps_per_path,
   output logic                            job_valid,
   output gbm_pkg::job_type                job,
   input  logic                            job_take
);

   logic signed [31:0]            level_ff, level_in;
   logic [gbm_pkg::STEP_W-1:0]    count_ff, count_in;
   gbm_pkg::job_type              queue_ff [2];
   logic                          wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0]                    fill_ff, fill_in;

   logic                          accept;
   logic [12:0]                   steps_eff;
   logic [gbm_pkg::STEP_W-1:0]    k_cur;
   logic signed [31:0]            lvl_cur;
   logic                          last;
   logic signed [32:0]            sum;
   gbm_pkg::job_type              new_job;

   assign req_full  = (fill_ff == 2'd2);
   assign accept    = req_push && !req_full;
   assign job_valid = (fill_ff != 2'd0);
   assign job       = queue_ff[rd_ptr_ff];

   always_comb begin
      if (steps_per_path < 13'd2) begin
         steps_eff = 13'd2;
      end else if (steps_per_path > 13'(gbm_pkg::MAX_STEPS)) begin
         steps_eff = 13'(gbm_pkg::MAX_STEPS);
      end else begin
         steps_eff = steps_per_path;
      end
      k_cur   = req_path_start ? '0 : count_ff;
      lvl_cur = req_path_start ? $signed(start_level) : level_ff;
      last    = ({1'b0, k_cur} + 13'd1) >= steps_eff;
      sum     = {lvl_cur[31], lvl_cur} + {req_increment[31], req_increment};
      new_job.level = lvl_cur;
      new_job.step  = k_cur;
      new_job.last  = last;

      level_in = level_ff;
      count_in = count_ff;
      if (accept) begin
         if (last) begin
            level_in = $signed(start_level);
            count_in = '0;
         end else begin
            priority if (sum > 33'sd2147483647) begin
               level_in = 32'sh7FFF_FFFF;
            end else if (sum < -33'sd2147483648) begin
               level_in = 32'sh8000_0000;
            end else begin
               level_in = sum[31:0];
            end
            count_in = k_cur + 1'b1;
         end
      end

      wr_ptr_in = accept ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = (job_take && job_valid) ? !rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + {1'b0, accept} - {1'b0, job_take && job_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff  <= '0;
         count_ff  <= '0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= '0;
      end else begin
         level_ff  <= level_in;
         count_ff  <= count_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         queue_ff[wr_ptr_ff] <= new_job;
      end
   end

endmodule

### src/gbm_back.sv
// Sequential price evaluator: exponent assembly, series exp, scaling, result register.
module gbm_back (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       job_valid,
   input  gbm_pkg::job_type           job,
   output logic                       job_take,
   input  logic [31:0]                start_price,
   input  logic [31:0]                drift_rate,
   input  logic [30:0]                volatility,
   input  logic [24:0]                time_step,
   input  logic                       rsp_pop,
   output logic                       rsp_empty,
   output logic [31:0]                rsp_price,
   output logic [11:0]                rsp_step_index,
   output logic                       rsp_last_of_path,
   output logic [1:0]                 rsp_status
);

   gbm_pkg::back_state_type state_ff, state_in;

   gbm_pkg::job_type   job_ff, job_in;
   logic [36:0]        half_ff, half_in;
   logic signed [38:0] a_ff, a_in;
   logic [36:0]        t_ff, t_in;
   logic [75:0]        acc_ff, acc_in;
   logic [30:0]        drift_ff, drift_in;
   logic [38:0]        dmag_ff, dmag_in;
   logic [28:0]        xm_ff, xm_in;
   logic               xneg_ff, xneg_in;
   logic [29:0]        ym_ff, ym_in;
   logic signed [6:0]  n_ff, n_in;
   logic [23:0]        f_ff, f_in;
   logic [29:0]        z_ff, z_in;
   logic [30:0]        term_ff, term_in;
   logic [30:0]        v_ff, v_in;
   logic [63:0]        qp_ff, qp_in;
   logic [3:0]         i_ff, i_in;
   logic [31:0]        m_ff, m_in;
   logic [63:0]        prod_ff, prod_in;
   logic               out_valid_ff, out_valid_in;
   logic [31:0]        price_ff, price_in;
   logic [11:0]        step_ff, step_in;
   logic               last_ff, last_in;
   logic [1:0]         status_ff, status_in;

   logic               a_neg, lvl_neg, out_fire;
   logic [38:0]        amag;
   logic [31:0]        wmag;
   logic signed [40:0] sd, sw, x;
   logic [40:0]        xabs;
   logic [5:0]         yint;
   logic [30:0]        qe, q;
   logic [34:0]        rem;
   logic [1:0]         sh;
   logic [6:0]         sr;
   logic [63:0]        p;
   logic               ovf;

   assign a_neg   = a_ff[38];
   assign amag    = a_neg ? 39'(-a_ff) : 39'(a_ff);
   assign lvl_neg = job_ff.level[31];
   assign wmag    = lvl_neg ? 32'(-job_ff.level) : 32'(job_ff.level);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gbm_pkg::ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      job_take  = 1'b0;
      out_fire  = 1'b0;
      job_in    = job_ff;
      half_in   = half_ff;
      a_in      = a_ff;
      t_in      = t_ff;
      acc_in    = acc_ff;
      drift_in  = drift_ff;
      dmag_in   = dmag_ff;
      xm_in     = xm_ff;
      xneg_in   = xneg_ff;
      ym_in     = ym_ff;
      n_in      = n_ff;
      f_in      = f_ff;
      z_in      = z_ff;
      term_in   = term_ff;
      v_in      = v_ff;
      qp_in     = qp_ff;
      i_in      = i_ff;
      m_in      = m_ff;
      prod_in   = prod_ff;
      price_in  = price_ff;
      step_in   = step_ff;
      last_in   = last_ff;
      status_in = status_ff;
      sd = '0; sw = '0; x = '0; xabs = '0; yint = '0;
      qe = '0; q = '0; rem = '0; sh = '0; sr = '0; p = '0; ovf = 1'b0;

      unique case (state_ff)
         gbm_pkg::ST_IDLE: begin
            if (job_valid) begin
               job_take = 1'b1;
               job_in   = job;
               state_in = gbm_pkg::ST_HALF;
            end
         end
         gbm_pkg::ST_HALF: begin
            half_in  = 37'((62'(volatility) * 62'(volatility)) >> 25);
            state_in = gbm_pkg::ST_TIME;
         end
         gbm_pkg::ST_TIME: begin
            a_in     = $signed({{7{drift_rate[31]}}, drift_rate}) - $signed({2'b00, half_ff});
            t_in     = 37'(job_ff.step) * 37'(time_step);
            state_in = gbm_pkg::ST_DRIFT_LO;
         end
         gbm_pkg::ST_DRIFT_LO: begin
            acc_in   = 76'(57'(amag[19:0]) * 57'(t_ff));
            state_in = gbm_pkg::ST_DRIFT_HI;
         end
         gbm_pkg::ST_DRIFT_HI: begin
            acc_in   = acc_ff + (76'(56'(amag[38:20]) * 56'(t_ff)) << 20);
            state_in = gbm_pkg::ST_DIFF;
         end
         gbm_pkg::ST_DIFF: begin
            dmag_in  = 39'((63'(volatility) * 63'(wmag)) >> gbm_pkg::FRAC_BITS);
            drift_in = (acc_ff[75:24] > 52'(gbm_pkg::DRIFT_CAP)) ? gbm_pkg::DRIFT_CAP
                                                                : acc_ff[54:24];
            state_in = gbm_pkg::ST_SUM;
         end
         gbm_pkg::ST_SUM: begin
            sd = a_neg ? -$signed({10'd0, drift_ff}) : $signed({10'd0, drift_ff});
            sw = lvl_neg ? -$signed({2'd0, dmag_ff}) : $signed({2'd0, dmag_ff});
            x  = sd + sw;
            xneg_in = x[40];
            xabs    = x[40] ? 41'(-x) : 41'(x);
            xm_in   = (xabs > 41'(gbm_pkg::X_LIMIT)) ? gbm_pkg::X_LIMIT : xabs[28:0];
            state_in = gbm_pkg::ST_LOG;
         end
         gbm_pkg::ST_LOG: begin
            ym_in    = 30'((58'(xm_ff) * 58'(gbm_pkg::LOG2E_Q28)) >> 28);
            state_in = gbm_pkg::ST_FRAC;
         end
         gbm_pkg::ST_FRAC: begin
            yint = ym_ff[29:24];
            if (!xneg_ff) begin
               n_in = $signed({1'b0, yint});
               f_in = ym_ff[23:0];
            end else if (ym_ff[23:0] == 24'd0) begin
               n_in = -$signed({1'b0, yint});
               f_in = '0;
            end else begin
               n_in = -$signed({1'b0, yint} + 7'd1);
               f_in = 24'(25'h100_0000 - {1'b0, ym_ff[23:0]});
            end
            state_in = gbm_pkg::ST_Z;
         end
         gbm_pkg::ST_Z: begin
            z_in     = 30'((54'(f_ff) * 54'(gbm_pkg::LN2_Q30)) >> gbm_pkg::FRAC_BITS);
            term_in  = gbm_pkg::ONE_Q30;
            m_in     = 32'(gbm_pkg::ONE_Q30);
            i_in     = 4'd1;
            state_in = gbm_pkg::ST_TERM_MUL;
         end
         gbm_pkg::ST_TERM_MUL: begin
            v_in     = 31'((61'(term_ff) * 61'(z_ff)) >> 30);
            state_in = gbm_pkg::ST_TERM_DIV;
         end
         gbm_pkg::ST_TERM_DIV: begin
            qp_in    = 64'(v_ff) * 64'(gbm_pkg::recip(i_ff));
            state_in = gbm_pkg::ST_TERM_FIX;
         end
         gbm_pkg::ST_TERM_FIX: begin
            // The reciprocal estimate is low by at most one.
            qe  = qp_ff[62:32];
            rem = {4'd0, v_ff} - (35'(qe) * 35'(i_ff));
            q   = (rem >= 35'(i_ff)) ? qe + 31'd1 : qe;
            term_in = q;
            m_in    = m_ff + 32'(q);
            i_in    = i_ff + 4'd1;
            state_in = (i_ff == 4'(gbm_pkg::EXP_TERMS)) ? gbm_pkg::ST_SCALE
                                                        : gbm_pkg::ST_TERM_MUL;
         end
         gbm_pkg::ST_SCALE: begin
            prod_in  = 64'(start_price) * 64'(m_ff);
            state_in = gbm_pkg::ST_OUT;
         end
         gbm_pkg::ST_OUT: begin
            if (n_ff > 7'sd30) begin
               sh  = 2'(n_ff - 7'sd30);
               ovf = (prod_ff >> (7'd32 - 7'(sh))) != 64'd0;
               p   = prod_ff << sh;
            end else begin
               sr = 7'(7'sd30 - n_ff);
               p  = (sr >= 7'd64) ? 64'd0 : (prod_ff >> sr);
            end
            ovf = ovf || (p[63:32] != 32'd0);
            priority if (start_price == 32'd0) begin
               price_in  = '0;
               status_in = gbm_pkg::STATUS_OK;
            end else if (ovf) begin
               price_in  = 32'hFFFF_FFFF;
               status_in = gbm_pkg::STATUS_OVERFLOW;
            end else if (p == 64'd0) begin
               price_in  = '0;
               status_in = gbm_pkg::STATUS_UNDERFLOW;
            end else begin
               price_in  = p[31:0];
               status_in = gbm_pkg::STATUS_OK;
            end
            step_in = job_ff.step;
            last_in = job_ff.last;
            if (!out_valid_ff || rsp_pop) begin
               out_fire = 1'b1;
               state_in = gbm_pkg::ST_IDLE;
            end else begin
               price_in  = price_ff;
               status_in = status_ff;
               step_in   = step_ff;
               last_in   = last_ff;
            end
         end
         default: state_in = gbm_pkg::ST_IDLE;
      endcase

      out_valid_in = out_fire ? 1'b1 : (rsp_pop ? 1'b0 : out_valid_ff);
   end

   always_ff @(posedge clock) begin
      job_ff    <= job_in;
      half_ff   <= half_in;
      a_ff      <= a_in;
      t_ff      <= t_in;
      acc_ff    <= acc_in;
      drift_ff  <= drift_in;
      dmag_ff   <= dmag_in;
      xm_ff     <= xm_in;
      xneg_ff   <= xneg_in;
      ym_ff     <= ym_in;
      n_ff      <= n_in;
      f_ff      <= f_in;
      z_ff      <= z_in;
      term_ff   <= term_in;
      v_ff      <= v_in;
      qp_ff     <= qp_in;
      i_ff      <= i_in;
      m_ff      <= m_in;
      prod_ff   <= prod_in;
      price_ff  <= price_in;
      step_ff   <= step_in;
      last_ff   <= last_in;
      status_ff <= status_in;
   end

   assign rsp_empty        = !out_valid_ff;
   assign rsp_price        = price_ff;
   assign rsp_step_index   = step_ff;
   assign rsp_last_of_path = last_ff;
   assign rsp_status       = status_ff;

endmodule

### src/gbm_path_generator_unit.sv
// Top level of the GBM path generator: register file and front/back hookup.
//
// Each request yields one price point of a geometric Brownian motion path. The
// front end updates the path level and step count in the cycle a request is
// pushed and queues the job in a two-entry queue; the back end evaluates the
// price with a single sequential unit and holds it in a result register until
// popped. The back end evaluates the exponential as a 13-term series, with a
// multiply, a reciprocal divide and a correction for each term. Up to two
// requests can wait in the queue while a result waits to be popped. Registers
// are written through the csr port, which is always ready; write them only
// while the unit is idle.
module gbm_path_generator_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  logic signed [31:0] req_increment,
   input  logic               req_path_start,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic [31:0]        rsp_price,
   output logic [11:0]        rsp_step_index,
   output logic               rsp_last_of_path,
   output logic [1:0]         rsp_status,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_data
);

   logic [31:0] start_price_ff, drift_rate_ff, start_level_ff;
   logic [30:0] volatility_ff;
   logic [24:0] time_step_ff;
   logic [12:0] steps_ff;

   logic             job_valid, job_take;
   gbm_pkg::job_type job;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_price_ff <= 32'd65536;
         drift_rate_ff  <= '0;
         volatility_ff  <= '0;
         start_level_ff <= '0;
         time_step_ff   <= 25'd16777216;
         steps_ff       <= 13'd256;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            gbm_pkg::CSR_START_PRICE:    start_price_ff <= csr_data;
            gbm_pkg::CSR_DRIFT_RATE:     drift_rate_ff  <= csr_data;
            gbm_pkg::CSR_VOLATILITY:     volatility_ff  <= csr_data[30:0];
            gbm_pkg::CSR_START_LEVEL:    start_level_ff <= csr_data;
            gbm_pkg::CSR_TIME_STEP:      time_step_ff   <= csr_data[24:0];
            gbm_pkg::CSR_STEPS_PER_PATH: steps_ff       <= csr_data[12:0];
            default: ;
         endcase
      end
   end

   gbm_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_increment  (req_increment),
      .req_path_start (req_path_start),
      .start_level    (start_level_ff),
      .steps_per_path (steps_ff),
      .job_valid      (job_valid),
      .job            (job),
      .job_take       (job_take)
   );

   gbm_back u_back (
      .clock            (clock),
      .reset            (reset),
      .job_valid        (job_valid),
      .job              (job),
      .job_take         (job_take),
      .start_price      (start_price_ff),
      .drift_rate       (drift_rate_ff),
      .volatility       (volatility_ff),
      .time_step        (time_step_ff),
      .rsp_pop          (rsp_pop),
      .rsp_empty        (rsp_empty),
      .rsp_price        (rsp_price),
      .rsp_step_index   (rsp_step_index),
      .rsp_last_of_path (rsp_last_of_path),
      .rsp_status       (rsp_status)
   );

endmodule
